// ===== hw/rtl/alu_with_condition_codes_top_defines.svh =====
// assertion macros for the execute block
`ifndef ALU_WITH_CONDITION_CODES_TOP_DEFINES_SVH
`define ALU_WITH_CONDITION_CODES_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle, checked outside reset
`define ALUC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aluc implication check failed");

// expression must never hold outside reset
`define ALUC_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("aluc forbidden condition seen");

`endif

// ===== hw/rtl/aluc_pkg.sv =====
// shared types and constants for the execute block
package aluc_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int WORD_W     = 32;
    localparam int FIELD_IDX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    // input op codes
    localparam logic [1:0] OP_ALU  = 2'd0;
    localparam logic [1:0] OP_COND = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    // alu function codes
    localparam logic [3:0] FUNC_ADD = 4'd0;
    localparam logic [3:0] FUNC_SUB = 4'd1;
    localparam logic [3:0] FUNC_AND = 4'd2;
    localparam logic [3:0] FUNC_XOR = 4'd3;

    // condition codes
    localparam logic [3:0] CC_ALWAYS = 4'd0;
    localparam logic [3:0] CC_LE     = 4'd1;
    localparam logic [3:0] CC_L      = 4'd2;
    localparam logic [3:0] CC_E      = 4'd3;
    localparam logic [3:0] CC_NE     = 4'd4;
    localparam logic [3:0] CC_GE     = 4'd5;
    localparam logic [3:0] CC_G      = 4'd6;

    typedef enum logic [1:0] {
        KIND_ALU,
        KIND_COND,
        KIND_LOAD,
        KIND_NOP
    } kind_t;

    typedef enum logic [1:0] {
        FN_ADD,
        FN_SUB,
        FN_AND,
        FN_XOR
    } alu_fn_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_LE,
        COND_L,
        COND_E,
        COND_NE,
        COND_GE,
        COND_G,
        COND_NEVER
    } cond_t;

    typedef struct packed {
        kind_t                    kind;
        alu_fn_t                  alu_fn;
        logic                     bad_fn;
        cond_t                    cond;
        logic [FIELD_IDX_W-1:0]   src_reg;
        logic [FIELD_IDX_W-1:0]   dst_reg;
        logic signed [WORD_W-1:0] load_value;
    } item_t;

    typedef struct packed {
        logic overflow;
        logic sign;
        logic zero;
    } flags_t;

    localparam flags_t FLAGS_RESET = '{overflow: 1'b0, sign: 1'b0, zero: 1'b1};

    typedef struct packed {
        logic signed [WORD_W-1:0] alu_result;
        logic                     cond_true;
        flags_t                   flags;
        logic                     status;
    } result_t;

endpackage

// ===== hw/rtl/aluc_front.sv =====
// front end: unpacks an incoming item and classifies it for execution
module aluc_front
    import aluc_pkg::*;
(
    input  logic [IN_USER_W-1:0] op,
    input  logic [IN_DATA_W-1:0] data,
    output item_t                item
);

    logic [3:0] func_code;

    assign func_code = data[3:0];

    always_comb
    begin
        item            = '0;
        item.kind       = KIND_NOP;
        item.alu_fn     = FN_ADD;
        item.bad_fn     = 1'b0;
        item.cond       = COND_NEVER;
        item.src_reg    = data[6:4];
        item.dst_reg    = data[9:7];
        item.load_value = data[41:10];
        case (op)
            OP_ALU:
            begin
                item.kind = KIND_ALU;
                case (func_code)
                    FUNC_ADD: item.alu_fn = FN_ADD;
                    FUNC_SUB: item.alu_fn = FN_SUB;
                    FUNC_AND: item.alu_fn = FN_AND;
                    FUNC_XOR: item.alu_fn = FN_XOR;
                    default:  item.bad_fn = 1'b1;
                endcase
            end
            OP_COND:
            begin
                item.kind = KIND_COND;
                case (func_code)
                    CC_ALWAYS: item.cond = COND_ALWAYS;
                    CC_LE:     item.cond = COND_LE;
                    CC_L:      item.cond = COND_L;
                    CC_E:      item.cond = COND_E;
                    CC_NE:     item.cond = COND_NE;
                    CC_GE:     item.cond = COND_GE;
                    CC_G:      item.cond = COND_G;
                    default:   item.cond = COND_NEVER;
                endcase
            end
            OP_LOAD:
            begin
                item.kind = KIND_LOAD;
            end
            default:
            begin
                item.kind = KIND_NOP;
            end
        endcase
    end

endmodule

// ===== hw/rtl/aluc_queue.sv =====
// short fifo of classified items between front and back
module aluc_queue
    import aluc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/aluc_back.sv =====
// back end: register file read, execute with flags, output register
module aluc_back
    import aluc_pkg::*;
#(
    parameter int NUM_REGS = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    localparam int IDX_W = $clog2(NUM_REGS);
    localparam int WRAP_W = 6;

    // register index wraps modulo the register count
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [FIELD_IDX_W-1:0] r);
        logic [WRAP_W-1:0] v;
        v = WRAP_W'(r);
        for (int i = 0; i < 4; i++)
        begin
            if (v >= WRAP_W'(NUM_REGS))
            begin
                v = v - WRAP_W'(NUM_REGS);
            end
        end
        return IDX_W'(v);
    endfunction

    logic [WORD_W-1:0] rf_mem_reg [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid_reg;

    logic              x_valid_reg;
    item_t             x_item_reg;
    logic [IDX_W-1:0]  x_widx_reg;
    logic [WORD_W-1:0] x_a_reg;
    logic [WORD_W-1:0] x_b_reg;

    flags_t            flags_reg;
    flags_t            flags_next;
    logic              out_valid_reg;
    result_t           out_result_reg;

    logic              out_free;
    logic              x_fire;
    logic              x_load;
    logic [IDX_W-1:0]  rd_a_idx;
    logic [IDX_W-1:0]  rd_b_idx;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] diff;
    logic [WORD_W-1:0] res;
    logic              of_bit;
    logic              lt;
    result_t           x_result;

    assign out_free   = !out_valid_reg || out_ready;
    assign x_fire     = x_valid_reg && out_free;
    assign x_load     = !x_valid_reg || x_fire;
    assign in_ready   = x_load;
    assign rd_a_idx   = wrap_idx(in_item.src_reg);
    assign rd_b_idx   = wrap_idx(in_item.dst_reg);
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    assign sum  = x_b_reg + x_a_reg;
    assign diff = x_b_reg - x_a_reg;
    assign lt   = flags_reg.sign ^ flags_reg.overflow;

    always_comb
    begin
        res        = '0;
        of_bit     = 1'b0;
        wr_en      = 1'b0;
        wr_data    = '0;
        flags_next = flags_reg;
        x_result   = '0;
        case (x_item_reg.kind)
            KIND_ALU:
            begin
                if (x_item_reg.bad_fn)
                begin
                    x_result.status = 1'b1;
                end
                else
                begin
                    case (x_item_reg.alu_fn)
                        FN_ADD:
                        begin
                            res    = sum;
                            of_bit = (x_a_reg[WORD_W-1] == x_b_reg[WORD_W-1])
                                     && (res[WORD_W-1] != x_a_reg[WORD_W-1]);
                        end
                        FN_SUB:
                        begin
                            res    = diff;
                            of_bit = (x_a_reg[WORD_W-1] != x_b_reg[WORD_W-1])
                                     && (res[WORD_W-1] != x_b_reg[WORD_W-1]);
                        end
                        FN_AND:  res = x_b_reg & x_a_reg;
                        FN_XOR:  res = x_b_reg ^ x_a_reg;
                        default: res = '0;
                    endcase
                    flags_next.overflow = of_bit;
                    flags_next.sign     = res[WORD_W-1];
                    flags_next.zero     = (res == '0);
                    wr_en               = 1'b1;
                    wr_data             = res;
                end
            end
            KIND_COND:
            begin
                case (x_item_reg.cond)
                    COND_ALWAYS: x_result.cond_true = 1'b1;
                    COND_LE:     x_result.cond_true = lt || flags_reg.zero;
                    COND_L:      x_result.cond_true = lt;
                    COND_E:      x_result.cond_true = flags_reg.zero;
                    COND_NE:     x_result.cond_true = !flags_reg.zero;
                    COND_GE:     x_result.cond_true = !lt;
                    COND_G:      x_result.cond_true = !lt && !flags_reg.zero;
                    default:     x_result.cond_true = 1'b0;
                endcase
            end
            KIND_LOAD:
            begin
                wr_en   = 1'b1;
                wr_data = x_item_reg.load_value;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
        x_result.alu_result = res;
        x_result.flags      = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= FLAGS_RESET;
            rf_valid_reg  <= '0;
        end
        else
        begin
            if (x_load)
            begin
                x_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= x_valid_reg;
            end
            if (x_fire)
            begin
                flags_reg <= flags_next;
                if (wr_en)
                begin
                    rf_valid_reg[x_widx_reg] <= 1'b1;
                end
            end
        end
    end

    // register file write and registered reads with write bypass
    always_ff @(posedge clk)
    begin
        if (x_fire && wr_en)
        begin
            rf_mem_reg[x_widx_reg] <= wr_data;
        end
        if (x_load && in_valid)
        begin
            x_item_reg <= in_item;
            x_widx_reg <= rd_b_idx;
            if (x_fire && wr_en && (x_widx_reg == rd_a_idx))
            begin
                x_a_reg <= wr_data;
            end
            else
            begin
                x_a_reg <= rf_valid_reg[rd_a_idx] ? rf_mem_reg[rd_a_idx] : '0;
            end
            if (x_fire && wr_en && (x_widx_reg == rd_b_idx))
            begin
                x_b_reg <= wr_data;
            end
            else
            begin
                x_b_reg <= rf_valid_reg[rd_b_idx] ? rf_mem_reg[rd_b_idx] : '0;
            end
        end
        if (x_fire)
        begin
            out_result_reg <= x_result;
        end
    end

endmodule

// ===== hw/rtl/alu_with_condition_codes_top.sv =====
// path: queue entry, then execute stage registers, then output register
// throughput: one item per cycle unless m_axis_tready stalls the output;
// the register file read is registered with a bypass from the write port
// reset: registers read as zero through per-entry valid bits, flags
// overflow 0, sign 0, zero 1, queue and stages empty
module alu_with_condition_codes_top
    import aluc_pkg::*;
#(
    parameter int NUM_REGS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // func_code[3:0], src_reg[6:4], dst_reg[9:7], load_value[41:10], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // alu_result[31:0], cond_true[32], flag_overflow[33], flag_sign[34],
    // flag_zero[35], status[36], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    item_t   front_item;
    logic    q_valid;
    logic    q_ready;
    item_t   q_item;
    result_t result;
    logic    flags_agree;

    aluc_front u_front
    (
        .op   (s_axis_tuser),
        .data (s_axis_tdata),
        .item (front_item)
    );

    aluc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    aluc_back #(
        .NUM_REGS (NUM_REGS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {
        (OUT_DATA_W - WORD_W - 5)'(0),
        result.status,
        result.flags.zero,
        result.flags.sign,
        result.flags.overflow,
        result.cond_true,
        result.alu_result
    };

    assign flags_agree = !result.flags.zero && (result.flags.sign == result.alu_result[WORD_W-1]);

`include "alu_with_condition_codes_top_defines.svh"

    // a rejected function leaves the result at zero
    `ALUC_ASSERT_IMPLY(a_bad_fn_zero, m_axis_tvalid && result.status, result.alu_result == '0)
    `ALUC_ASSERT_NEVER(a_status_and_cond, m_axis_tvalid && result.status && result.cond_true)
    // a nonzero result only comes from an alu item, so the flags follow it
    `ALUC_ASSERT_IMPLY(a_flags_follow, m_axis_tvalid && (result.alu_result != '0), flags_agree)

endmodule
